FILE: src/fwbp_pkg.sv
// ----------------------------------------------------------------------------
// fwbp_pkg
// Shared types and constants of the fixed width bit packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fwbp_pkg;

  localparam int unsigned WordBits    = 64;
  localparam int unsigned WidthBits   = 7;
  localparam int unsigned CountBits   = 17;
  localparam int unsigned IndexBits   = 16;
  localparam int unsigned FillBits    = 6;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QPtrBits    = $clog2(QueueDepth);
  localparam int unsigned QCntBits    = $clog2(QueueDepth + 1);

  localparam logic [CountBits-1:0] MaxElements = 17'd65536;
  localparam logic [WidthBits-1:0] MaxWidth    = 7'd64;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgFieldWidth    = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgElementCount  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgCapacityWords = 2'd2;

  localparam logic StatusOk       = 1'b0;
  localparam logic StatusCapacity = 1'b1;

  typedef struct packed {
    logic [WordBits-1:0] value;
    logic                last;
    logic                err;
  } entry_t;

  typedef struct packed {
    logic                 clear;
    logic [WidthBits-1:0] width;
  } ctl_t;

endpackage

`default_nettype wire

FILE: src/fwbp_if.sv
// ----------------------------------------------------------------------------
// fwbp_if
// Valid/ready channels for input values and packed output words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fwbp_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface fwbp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] word;
  logic [15:0] word_pos;
  logic        final_word;
  logic        status;

  modport source (output valid, output word, output word_pos, output final_word,
                  output status, input ready);
  modport sink (input valid, input word, input word_pos, input final_word,
                input status, output ready);
endinterface

`default_nettype wire

FILE: src/fwbp_front.sv
// ----------------------------------------------------------------------------
// fwbp_front
// Configuration registers, job counting, capacity check and value masking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fwbp_front
  import fwbp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [CountBits-1:0]  cfg_data_i,
  fwbp_in_if.sink                    in_bus,
  input  wire logic                  q_ready_i,
  output logic                       q_push_o,
  output entry_t                     q_entry_o,
  output ctl_t                       ctl_o
);

  logic [WidthBits-1:0] width_q;
  logic [CountBits-1:0] count_q;
  logic [CountBits-1:0] cap_q;
  logic [CountBits-1:0] seen_q, seen_d;

  logic                  cfg_hit;
  logic [WidthBits-1:0]  w_eff;
  logic [CountBits-1:0]  n_eff;
  logic [23:0]           prod;
  logic [17:0]           need;
  logic                  ovf;
  logic                  accept;
  logic                  last;
  logic [WordBits-1:0]   mask;

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == CfgFieldWidth) ||
                                (cfg_idx_i == CfgElementCount) ||
                                (cfg_idx_i == CfgCapacityWords));

  always_comb begin
    if (width_q == '0) begin
      w_eff = 7'd1;
    end else if (width_q > MaxWidth) begin
      w_eff = MaxWidth;
    end else begin
      w_eff = width_q;
    end
  end

  assign n_eff = (count_q > MaxElements) ? MaxElements : count_q;
  assign prod  = 24'(n_eff) * 24'(w_eff);
  assign need  = 18'((prod + 24'd63) >> 6);
  assign ovf   = need > 18'(cap_q);

  assign mask = (w_eff == MaxWidth) ? '1 : ((64'd1 << w_eff) - 64'd1);

  assign in_bus.ready = q_ready_i;
  assign accept       = in_bus.valid && q_ready_i;
  assign seen_d       = seen_q + 17'd1;
  assign last         = seen_d >= n_eff;

  assign q_push_o        = accept && (n_eff != '0) && (!ovf || last);
  assign q_entry_o.value = in_bus.value & mask;
  assign q_entry_o.last  = last;
  assign q_entry_o.err   = ovf;

  assign ctl_o.clear = cfg_hit;
  assign ctl_o.width = w_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 7'd1;
      count_q <= '0;
      cap_q   <= '0;
      seen_q  <= '0;
    end else if (cfg_hit) begin
      seen_q <= '0;
      unique case (cfg_idx_i)
        CfgFieldWidth:    width_q <= cfg_data_i[WidthBits-1:0];
        CfgElementCount:  count_q <= cfg_data_i;
        CfgCapacityWords: cap_q   <= cfg_data_i;
        default:          ;
      endcase
    end else if (accept && (n_eff != '0)) begin
      seen_q <= last ? '0 : seen_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/fwbp_queue.sv
// ----------------------------------------------------------------------------
// fwbp_queue
// Short queue between the front and the packing back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fwbp_queue
  import fwbp_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   clear_i,
  input  wire logic   push_i,
  input  entry_t      entry_i,
  output logic        ready_o,
  output logic        valid_o,
  output entry_t      entry_o,
  input  wire logic   pop_i
);

  entry_t              slot_q [QueueDepth];
  logic [QPtrBits-1:0] wr_q, rd_q;
  logic [QCntBits-1:0] cnt_q;

  assign ready_o = cnt_q != QCntBits'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign entry_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else if (clear_i) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPtrBits'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPtrBits'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + QCntBits'(push_i) - QCntBits'(pop_i);
    end
  end

  a_no_overfill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntBits'(QueueDepth))
    else $error("queue holds more words than its depth");

endmodule

`default_nettype wire

FILE: src/fwbp_back.sv
// ----------------------------------------------------------------------------
// fwbp_back
// Bit accumulator: shifts values into the pending word and emits results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fwbp_back
  import fwbp_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  ctl_t        ctl_i,
  input  wire logic   q_valid_i,
  input  entry_t      q_entry_i,
  output logic        q_pop_o,
  fwbp_out_if.source  out_bus
);

  // packing state
  logic [WordBits-1:0]  store_q;
  logic [FillBits-1:0]  fill_q;
  logic [IndexBits-1:0] widx_q;

  // output stage and held tail word
  logic                 out_valid_q;
  logic [WordBits-1:0]  out_word_q;
  logic [IndexBits-1:0] out_idx_q;
  logic                 out_final_q;
  logic                 out_status_q;
  logic                 tail_v_q;
  logic [WordBits-1:0]  tail_word_q;
  logic [IndexBits-1:0] tail_idx_q;

  logic                 slot_free;
  logic [WidthBits-1:0] total;
  logic                 full;
  logic [WordBits-1:0]  merged;
  logic [WordBits-1:0]  spill;
  logic [WordBits-1:0]  store_n;
  logic [FillBits-1:0]  fill_n;
  logic [IndexBits-1:0] widx_n;
  logic                 has_tail;
  logic                 any_res;

  assign slot_free = !out_valid_q || out_bus.ready;

  assign total  = WidthBits'(fill_q) + ctl_i.width;
  assign full   = total[WidthBits-1];
  assign merged = store_q | (q_entry_i.value << fill_q);
  assign spill  = (fill_q == '0) ? '0 :
                  (q_entry_i.value >> (MaxWidth - WidthBits'(fill_q)));

  always_comb begin
    if (full) begin
      store_n = spill;
      fill_n  = total[FillBits-1:0];
      widx_n  = widx_q + 1'b1;
    end else begin
      store_n = merged;
      fill_n  = total[FillBits-1:0];
      widx_n  = widx_q;
    end
  end

  assign has_tail = q_entry_i.last && (fill_n != '0);
  assign any_res  = q_entry_i.err || full || has_tail;
  assign q_pop_o  = q_valid_i && !tail_v_q && (slot_free || !any_res);

  assign out_bus.valid      = out_valid_q;
  assign out_bus.word       = out_word_q;
  assign out_bus.word_pos   = out_idx_q;
  assign out_bus.final_word = out_final_q;
  assign out_bus.status     = out_status_q;

  always_ff @(posedge clk_i) begin
    if (tail_v_q && slot_free) begin
      out_word_q   <= tail_word_q;
      out_idx_q    <= tail_idx_q;
      out_final_q  <= 1'b1;
      out_status_q <= StatusOk;
    end else if (q_pop_o && any_res) begin
      if (q_entry_i.err) begin
        out_word_q   <= '0;
        out_idx_q    <= '0;
        out_final_q  <= 1'b1;
        out_status_q <= StatusCapacity;
      end else if (full) begin
        out_word_q   <= merged;
        out_idx_q    <= widx_q;
        out_final_q  <= q_entry_i.last && (fill_n == '0);
        out_status_q <= StatusOk;
      end else begin
        out_word_q   <= store_n;
        out_idx_q    <= widx_n;
        out_final_q  <= 1'b1;
        out_status_q <= StatusOk;
      end
    end
    if (q_pop_o && !q_entry_i.err && full && has_tail) begin
      tail_word_q <= store_n;
      tail_idx_q  <= widx_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q     <= '0;
      fill_q      <= '0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
      tail_v_q    <= 1'b0;
    end else begin
      if (tail_v_q && slot_free) begin
        out_valid_q <= 1'b1;
        tail_v_q    <= 1'b0;
      end else if (q_pop_o && any_res) begin
        out_valid_q <= 1'b1;
        tail_v_q    <= !q_entry_i.err && full && has_tail;
      end else if (out_bus.ready) begin
        out_valid_q <= 1'b0;
      end

      if (ctl_i.clear) begin
        store_q <= '0;
        fill_q  <= '0;
        widx_q  <= '0;
      end else if (q_pop_o) begin
        if (q_entry_i.last || q_entry_i.err) begin
          store_q <= '0;
          fill_q  <= '0;
          widx_q  <= '0;
        end else begin
          store_q <= store_n;
          fill_q  <= fill_n;
          widx_q  <= widx_n;
        end
      end
    end
  end

  a_tail_behind_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_v_q |-> out_valid_q)
    else $error("tail word held without a word in the output stage");

  a_error_is_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == StatusCapacity)) |-> (out_final_q && (out_word_q == '0)))
    else $error("capacity error word is not a final empty word");

  a_tail_from_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tail_v_q) |-> $past(q_pop_o))
    else $error("tail word appeared without a dequeued value");

endmodule

`default_nettype wire

FILE: src/fixed_width_bit_packer_top.sv
// ----------------------------------------------------------------------------
// fixed_width_bit_packer_top
// LSB-first packing of fixed width fields into 64-bit words.
// ----------------------------------------------------------------------------
// Accepts one value per cycle while the queue has room, and packs its low
// field_width bits after the earlier ones, emitting each full 64-bit word with
// its index. A job ends after element_count values; a partial tail is zero
// padded and flagged final. If the job needs more words than capacity_words, the
// values are consumed and the last one returns a single error word (status 1). A
// value that both fills a word and ends the job with a partial tail gives two
// words, the second held in a tail register behind the single output register.
// An accepted value reaches its word through the two-entry queue and the
// output register. Configuration register writes clear any job in progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_width_bit_packer_top
  import fwbp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [CountBits-1:0]  cfg_data_i,
  fwbp_in_if.sink                    in_bus,
  fwbp_out_if.source                 out_bus
);

  ctl_t   ctl;
  logic   q_ready, q_push, q_valid, q_pop;
  entry_t q_in, q_out;

  fwbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_bus     (in_bus),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_entry_o  (q_in),
    .ctl_o      (ctl)
  );

  fwbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (ctl.clear),
    .push_i  (q_push),
    .entry_i (q_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .entry_o (q_out),
    .pop_i   (q_pop)
  );

  fwbp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .q_valid_i (q_valid),
    .q_entry_i (q_out),
    .q_pop_o   (q_pop),
    .out_bus   (out_bus)
  );

endmodule

`default_nettype wire

FILE: tb/fwbp_chk.sv
// ----------------------------------------------------------------------------
// fwbp_checker
// Watches the value and word channels and the register port, predicts every
// packed word and compares it field by field with what the packer emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwbp_checker
  import fwbp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [CountBits-1:0]  cfg_data_i,
  fwbp_in_if                         in_mon,
  fwbp_out_if                        out_mon,
  output int unsigned                fail_count_o,
  output int unsigned                words_due_o
);

  typedef struct {
    logic [WordBits-1:0]  word;
    logic [IndexBits-1:0] idx;
    logic                 fin;
    logic                 st;
  } packed_word_t;

  packed_word_t word_q[$];

  logic [WidthBits-1:0] width_r = 7'd1;
  logic [CountBits-1:0] count_r = '0;
  logic [CountBits-1:0] cap_r   = '0;

  logic [WordBits-1:0]  pend_bits = '0;
  logic [FillBits-1:0]  pend_cnt  = '0;
  logic [CountBits-1:0] seen      = '0;
  logic [CountBits-1:0] emitted   = '0;

  int unsigned errs   = 0;
  int unsigned due_n  = 0;

  assign fail_count_o = errs;
  assign words_due_o  = due_n;

  task automatic report(input string msg);
    if (errs < 100) $display("%0t ns: mismatch: %s", $time, msg);
    errs++;
  endtask

  task automatic clear_job();
    pend_bits = '0;
    pend_cnt  = '0;
    seen      = '0;
    emitted   = '0;
  endtask

  task automatic expect_word(input logic [WordBits-1:0] word, input logic [IndexBits-1:0] idx,
                             input logic fin, input logic st);
    packed_word_t e;
    e.word = word;
    e.idx  = idx;
    e.fin  = fin;
    e.st   = st;
    word_q.push_back(e);
  endtask

  task automatic pack_value(input logic [WordBits-1:0] v);
    int unsigned w, n, need, p, total;
    logic [WordBits-1:0] mask, fld;
    bit last;
    w = (width_r == 0) ? 1 : ((width_r > MaxWidth) ? WordBits : width_r);
    n = (count_r > MaxElements) ? MaxElements : count_r;
    if (n == 0) return;
    need = (n * w + WordBits - 1) / WordBits;
    seen = seen + 17'd1;
    last = (seen >= n);
    if (need > cap_r) begin
      if (last) begin
        expect_word('0, '0, 1'b1, StatusCapacity);
        clear_job();
      end
      return;
    end
    mask  = (w >= WordBits) ? '1 : ((64'd1 << w) - 64'd1);
    fld   = v & mask;
    p     = pend_cnt;
    total = p + w;
    if (total >= WordBits) begin
      expect_word(pend_bits | (fld << p), emitted[IndexBits-1:0],
                  last && (total == WordBits), StatusOk);
      pend_bits = (p == 0) ? '0 : (fld >> (WordBits - p));
      pend_cnt  = FillBits'(total - WordBits);
      emitted   = emitted + 17'd1;
    end else begin
      pend_bits = pend_bits | (fld << p);
      pend_cnt  = FillBits'(total);
    end
    if (last) begin
      if (pend_cnt != 0) expect_word(pend_bits, emitted[IndexBits-1:0], 1'b1, StatusOk);
      clear_job();
    end
  endtask

  task automatic check_word();
    packed_word_t e;
    if (word_q.size() == 0) begin
      report($sformatf("unexpected word %h position %0d", out_mon.word, out_mon.word_pos));
      return;
    end
    e = word_q.pop_front();
    if (out_mon.word !== e.word)
      report($sformatf("word %h, expected %h", out_mon.word, e.word));
    if (out_mon.word_pos !== e.idx)
      report($sformatf("word_pos %0d, expected %0d", out_mon.word_pos, e.idx));
    if (out_mon.final_word !== e.fin)
      report($sformatf("final_word %b, expected %b", out_mon.final_word, e.fin));
    if (out_mon.status !== e.st)
      report($sformatf("status %b, expected %b", out_mon.status, e.st));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_r = 7'd1;
      count_r = '0;
      cap_r   = '0;
      clear_job();
      word_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_word();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFieldWidth: begin
            width_r = cfg_data_i[WidthBits-1:0];
            clear_job();
          end
          CfgElementCount: begin
            count_r = cfg_data_i;
            clear_job();
          end
          CfgCapacityWords: begin
            cap_r = cfg_data_i;
            clear_job();
          end
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) pack_value(in_mon.value);
    end
    due_n = word_q.size();
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression of the fixed width bit packer: directed jobs for the width and
// count extremes, capacity errors, two-word steps, abandoned jobs and ignored
// register writes, then randomized jobs with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fwbp_pkg::*;

  localparam logic [CfgIdxBits-1:0] CfgSpare = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  logic [CountBits-1:0]  cfg_data_i;
  int unsigned           mismatches;
  int unsigned           words_due;
  bit                    in_burst;

  fwbp_in_if  in_bus ();
  fwbp_out_if out_bus ();

  fixed_width_bit_packer_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_bus     (in_bus),
    .out_bus    (out_bus)
  );

  fwbp_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .fail_count_o (mismatches),
    .words_due_o  (words_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #(64'd10_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (in_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_value(input logic [63:0] v);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.value <= v;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (words_due != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic set_job(input logic [CountBits-1:0] wd, input logic [CountBits-1:0] nd,
                         input logic [CountBits-1:0] cd);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgFieldWidth;
    cfg_data_i <= wd;
    @(negedge clk_i);
    cfg_idx_i  <= CfgElementCount;
    cfg_data_i <= nd;
    @(negedge clk_i);
    cfg_idx_i  <= CfgCapacityWords;
    cfg_data_i <= cd;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // output side stalls, with stall-free stretches
  initial begin
    int unsigned hold, stretch;
    bit stall_free;
    hold = 0;
    stretch = 0;
    stall_free = 1'b0;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stretch == 0) begin
        stretch = $urandom_range(50, 400);
        stall_free = ($urandom_range(0, 3) == 0);
      end
      stretch--;
      if (hold != 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else if (!stall_free && $urandom_range(0, 3) == 0) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned n_rand, r, wd, nd, cd, ew, en, need, nsend, hold_at, i;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgFieldWidth;
    cfg_data_i    = '0;
    in_bus.valid  = 1'b0;
    in_bus.value  = '0;
    in_burst      = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty job after reset, values are dropped
    push_value('1);
    push_value(64'h0123_4567_89ab_cdef);
    drain();

    // full-width fields
    set_job(17'd64, 17'd3, 17'd3);
    push_value('1);
    push_value('0);
    push_value(64'h8000_0000_0000_0001);
    drain();

    // width 0 acts as 1, partial tail
    set_job(17'd0, 17'd5, 17'd1);
    push_value(64'd1);
    push_value(64'd0);
    push_value(64'hffff_ffff_ffff_fffe);
    push_value(64'd3);
    push_value('1);
    drain();

    // oversized width saturates
    set_job(17'd127, 17'd1, 17'd1);
    push_value(64'hdead_beef_cafe_f00d);
    drain();

    // capacity too small
    set_job(17'd40, 17'd2, 17'd1);
    push_value('1);
    push_value('1);
    drain();
    set_job(17'd5, 17'd1, 17'd0);
    push_value('1);
    drain();

    // full word and tail from one value, spare index write in between
    set_job(17'd48, 17'd2, 17'd2);
    push_value(64'h1234_5678_9abc_def0);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgSpare;
    cfg_data_i <= 17'h1ffff;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    repeat (2) @(negedge clk_i);
    push_value('1);
    drain();

    // oversized count, job abandoned by the next register write
    set_job(17'd13, 17'd131071, 17'd131071);
    for (i = 0; i < 10; i++) push_value(rand_value());
    drain();

    n_rand = 0;
    while (n_rand < 950) begin
      r = $urandom_range(0, 19);
      if (r == 0) wd = 0;
      else if (r == 1) wd = $urandom_range(65, 127);
      else if (r < 4) wd = 64;
      else wd = $urandom_range(1, 64);
      ew = (wd == 0) ? 1 : ((wd > 64) ? 64 : wd);
      if ($urandom_range(0, 7) == 0) wd = wd | ($urandom_range(0, 1023) << 7);

      r = $urandom_range(0, 19);
      if (r == 0) nd = 0;
      else if (r == 1) nd = $urandom_range(65536, 131071);
      else if (r < 4) nd = $urandom_range(41, 200);
      else nd = $urandom_range(1, 40);
      en = (nd > 65536) ? 65536 : nd;
      need = (en * ew + 63) / 64;

      r = $urandom_range(0, 19);
      if (r < 3 && need > 0) cd = need - 1;
      else if (r == 3) cd = $urandom_range(0, 131071);
      else if (r == 4) cd = 131071;
      else cd = need + $urandom_range(0, 3);

      in_burst = ($urandom_range(0, 4) == 0);
      set_job(CountBits'(wd), CountBits'(nd), CountBits'(cd));

      if (en == 0) nsend = $urandom_range(1, 3);
      else if (en > 200) nsend = $urandom_range(20, 80);
      else nsend = en * $urandom_range(1, 3);
      hold_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, nsend - 1) : nsend;

      for (i = 0; i < nsend; i++) begin
        if (i == hold_at) begin
          // hold off until all words are out
          in_bus.valid <= 1'b0;
          @(negedge clk_i);
          while (words_due != 0) @(negedge clk_i);
        end
        push_value(rand_value());
      end
      if (en != 0) n_rand += nsend;
      drain();
    end

    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
